>>> rtl/core/oalru_pkg.sv
// ----------------------------------------------------------------------------
// oalru_pkg
// Shared types, constants and helpers for the owner-aware LRU victim select.
// ----------------------------------------------------------------------------
package oalru_pkg;

  localparam int WAYS       = 16;
  localparam int SETS       = 2048;
  localparam int OWNER_SCAN = 4;

  localparam int WAY_W   = 4;
  localparam int AGE_W   = $clog2(WAYS);
  localparam int SET_W   = $clog2(SETS);
  localparam int CPU_W   = 2;
  localparam int SCAN    = (OWNER_SCAN < WAYS) ? OWNER_SCAN : WAYS;

  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  localparam logic [1:0] REASON_INVALID = 2'd0;
  localparam logic [1:0] REASON_OWNER   = 2'd1;
  localparam logic [1:0] REASON_OLDEST  = 2'd2;

  typedef logic [WAYS-1:0] way_vec_t;

  typedef struct packed {
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][CPU_W-1:0] owner;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic way_vec_t lowest_one(input way_vec_t x);
    return x & (~x + way_vec_t'(1));
  endfunction

  function automatic logic [WAY_W-1:0] onehot_to_idx(input way_vec_t x);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (x[i]) idx = idx | WAY_W'(i);
    end
    return idx;
  endfunction

  function automatic row_t reset_row();
    row_t r;
    for (int i = 0; i < WAYS; i++) begin
      r.age[i]   = AGE_W'(i);
      r.valid[i] = 1'b0;
      r.owner[i] = '0;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/oalru_ram.sv
// ----------------------------------------------------------------------------
// oalru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oalru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/owner_aware_lru_victim_select.sv
// ----------------------------------------------------------------------------
// owner_aware_lru_victim_select
// LRU replacement state for a shared cache, with owner-preferring victim pick.
// One set row (ages, valid bits, owners) per RAM entry: read, then modify/write.
// Row data is registered at the RAM read port, the result in the output register.
// Transactions run one at a time (row read, then compute/write back);
// a query waits in the compute cycle while the output register is still full.
// Reset: synchronous; a clearing pass writes all SETS (2048) rows with their reset
// value, and no input transaction is taken until it ends.
// ----------------------------------------------------------------------------
module owner_aware_lru_victim_select (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [oalru_pkg::CPU_W-1:0]         cpu,
  input  logic [10:0]                         set_index,
  input  logic [oalru_pkg::WAY_W-1:0]         way,
  input  logic                                is_writeback,
  input  logic                                hit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oalru_pkg::WAY_W-1:0]         victim_way,
  output logic [1:0]                          victim_reason
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]                    state, state_next;
  logic [oalru_pkg::SET_W-1:0]   clr_addr;

  logic                          kind_q, wb_q, hit_q;
  logic [oalru_pkg::CPU_W-1:0]   cpu_q;
  logic [oalru_pkg::SET_W-1:0]   set_q;
  logic [oalru_pkg::WAY_W-1:0]   way_q;

  oalru_pkg::row_t               row, row_new;
  logic                          ram_we, ram_re;
  logic [oalru_pkg::SET_W-1:0]   ram_waddr;
  logic [oalru_pkg::ROW_W-1:0]   ram_wdata, ram_rdata;

  logic                          in_acc, out_free, upd_en, q_done;
  logic [oalru_pkg::WAY_W-1:0]   pick_way;
  logic [1:0]                    pick_reason;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign row      = oalru_pkg::row_t'(ram_rdata);

  oalru_ram #(
    .WIDTH (oalru_pkg::ROW_W),
    .DEPTH (oalru_pkg::SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (set_index[oalru_pkg::SET_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_re = in_acc;

  // victim selection over the row just read
  always_comb begin
    oalru_pkg::way_vec_t inval, oldest, own_match, match, first;
    oalru_pkg::way_vec_t own_sel [oalru_pkg::SCAN];
    logic [oalru_pkg::SCAN-1:0] own_hit;
    oalru_pkg::way_vec_t chosen;

    inval = ~row.valid;
    for (int w = 0; w < oalru_pkg::WAYS; w++) begin
      own_match[w] = (row.owner[w] == cpu_q);
    end
    for (int p = 0; p < oalru_pkg::SCAN; p++) begin
      for (int w = 0; w < oalru_pkg::WAYS; w++) begin
        match[w] = (row.age[w] == oalru_pkg::AGE_W'(oalru_pkg::WAYS - 1 - p));
      end
      first      = oalru_pkg::lowest_one(match);
      own_sel[p] = first;
      own_hit[p] = |(first & own_match);
    end
    // first way holding the largest age
    for (int w = 0; w < oalru_pkg::WAYS; w++) begin
      oldest[w] = 1'b1;
      for (int v = 0; v < oalru_pkg::WAYS; v++) begin
        if (v < w && !(row.age[w] > row.age[v])) oldest[w] = 1'b0;
        if (v > w && (row.age[v] > row.age[w]))  oldest[w] = 1'b0;
      end
    end

    chosen      = oldest;
    pick_reason = oalru_pkg::REASON_OLDEST;
    for (int p = oalru_pkg::SCAN - 1; p >= 0; p--) begin
      if (own_hit[p]) begin
        chosen      = own_sel[p];
        pick_reason = oalru_pkg::REASON_OWNER;
      end
    end
    if (|inval) begin
      chosen      = oalru_pkg::lowest_one(inval);
      pick_reason = oalru_pkg::REASON_INVALID;
    end
    pick_way = oalru_pkg::onehot_to_idx(chosen);
  end

  // promote / fill
  always_comb begin
    logic [oalru_pkg::AGE_W-1:0] cur;
    cur     = row.age[way_q];
    row_new = row;
    for (int i = 0; i < oalru_pkg::WAYS; i++) begin
      if (row.age[i] < cur) row_new.age[i] = row.age[i] + oalru_pkg::AGE_W'(1);
    end
    row_new.age[way_q] = '0;
    if (!hit_q) begin
      row_new.valid[way_q] = 1'b1;
      row_new.owner[way_q] = cpu_q;
    end
  end

  assign upd_en = (state == ST_EXEC) && (kind_q == oalru_pkg::KIND_UPDATE) &&
                  (int'(way_q) < oalru_pkg::WAYS) && !(wb_q && hit_q);
  assign q_done = (state == ST_EXEC) && (kind_q == oalru_pkg::KIND_QUERY) && out_free;

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = oalru_pkg::ROW_W'(oalru_pkg::reset_row());
    end else begin
      ram_we    = upd_en;
      ram_waddr = set_q;
      ram_wdata = oalru_pkg::ROW_W'(row_new);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (&clr_addr) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = ST_EXEC;
      ST_EXEC:  if (kind_q == oalru_pkg::KIND_UPDATE || out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + oalru_pkg::SET_W'(1);
      if (q_done)         out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_q <= kind;
      cpu_q  <= cpu;
      set_q  <= set_index[oalru_pkg::SET_W-1:0];
      way_q  <= way;
      wb_q   <= is_writeback;
      hit_q  <= hit;
    end
    if (q_done) begin
      victim_way    <= pick_way;
      victim_reason <= pick_reason;
    end
  end

endmodule

>>> rtl/core/oalru_checker.sv
// ----------------------------------------------------------------------------
// oalru_checker
// Port-level checks for owner_aware_lru_victim_select, bound to the top level.
// ----------------------------------------------------------------------------
module oalru_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [oalru_pkg::WAY_W-1:0]   victim_way,
  input logic [1:0]                    victim_reason
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(victim_way) && $stable(victim_reason))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction taken while one is in flight");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("ready or result during clearing pass");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a transaction in flight");

endmodule

bind owner_aware_lru_victim_select oalru_checker u_oalru_checker (.*);

>>> bench/owner_aware_lru_victim_select_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owner_aware_lru_victim_select_checker
// Tracks per-set LRU ages, valid bits and owners from accepted transactions,
// predicts each victim query and compares it with the returned transaction.
// ----------------------------------------------------------------------------
module owner_aware_lru_victim_select_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        kind,
  input  logic [oalru_pkg::CPU_W-1:0] cpu,
  input  logic [10:0]                 set_index,
  input  logic [oalru_pkg::WAY_W-1:0] way,
  input  logic                        is_writeback,
  input  logic                        hit,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [oalru_pkg::WAY_W-1:0] victim_way,
  input  logic [1:0]                  victim_reason,
  output int                          fail_count,
  output int                          due_count
);

  localparam int SCAN_LEN = (oalru_pkg::OWNER_SCAN < oalru_pkg::WAYS) ?
                            oalru_pkg::OWNER_SCAN : oalru_pkg::WAYS;

  typedef struct packed {
    logic [oalru_pkg::WAY_W-1:0] way;
    logic [1:0]                  reason;
  } victim_t;

  logic [oalru_pkg::AGE_W-1:0] age_tbl   [oalru_pkg::SETS][oalru_pkg::WAYS];
  logic                        valid_tbl [oalru_pkg::SETS][oalru_pkg::WAYS];
  logic [oalru_pkg::CPU_W-1:0] owner_tbl [oalru_pkg::SETS][oalru_pkg::WAYS];

  victim_t victims_due[$];
  int      errs = 0;

  assign fail_count = errs;

  function automatic victim_t choose_victim(input int s,
                                            input logic [oalru_pkg::CPU_W-1:0] c);
    victim_t pick;
    int      target;
    int      hitw;
    int      oldest;
    for (int w = 0; w < oalru_pkg::WAYS; w++) begin
      if (!valid_tbl[s][w]) begin
        pick.way    = oalru_pkg::WAY_W'(w);
        pick.reason = oalru_pkg::REASON_INVALID;
        return pick;
      end
    end
    for (int pos = 0; pos < SCAN_LEN; pos++) begin
      target = oalru_pkg::WAYS - 1 - pos;
      hitw   = -1;
      for (int w = 0; w < oalru_pkg::WAYS; w++) begin
        if (hitw < 0 && int'(age_tbl[s][w]) == target) hitw = w;
      end
      if (hitw >= 0 && owner_tbl[s][hitw] == c) begin
        pick.way    = oalru_pkg::WAY_W'(hitw);
        pick.reason = oalru_pkg::REASON_OWNER;
        return pick;
      end
    end
    oldest = 0;
    for (int w = 1; w < oalru_pkg::WAYS; w++) begin
      if (age_tbl[s][w] > age_tbl[s][oldest]) oldest = w;
    end
    pick.way    = oalru_pkg::WAY_W'(oldest);
    pick.reason = oalru_pkg::REASON_OLDEST;
    return pick;
  endfunction

  function automatic void apply_access(input int s, input int w,
                                       input logic [oalru_pkg::CPU_W-1:0] c,
                                       input logic wb, input logic h);
    logic [oalru_pkg::AGE_W-1:0] cur;
    if (w >= oalru_pkg::WAYS || (wb && h)) return;
    cur = age_tbl[s][w];
    for (int i = 0; i < oalru_pkg::WAYS; i++) begin
      if (age_tbl[s][i] < cur) age_tbl[s][i] = age_tbl[s][i] + 1'b1;
    end
    age_tbl[s][w] = '0;
    if (!h) begin
      valid_tbl[s][w] = 1'b1;
      owner_tbl[s][w] = c;
    end
  endfunction

  always @(posedge clk) begin
    victim_t want;
    int      s;
    if (rst) begin
      for (int i = 0; i < oalru_pkg::SETS; i++) begin
        for (int w = 0; w < oalru_pkg::WAYS; w++) begin
          age_tbl[i][w]   = oalru_pkg::AGE_W'(w);
          valid_tbl[i][w] = 1'b0;
          owner_tbl[i][w] = '0;
        end
      end
      victims_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (victims_due.size() == 0) begin
          $error("unexpected victim transaction: way %0d, reason %0d",
                 victim_way, victim_reason);
          errs++;
        end else begin
          want = victims_due.pop_front();
          if (victim_way !== want.way) begin
            $error("victim_way: expected %0d, actual %0d", want.way, victim_way);
            errs++;
          end
          if (victim_reason !== want.reason) begin
            $error("victim_reason: expected %0d, actual %0d", want.reason, victim_reason);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        s = int'(set_index) % oalru_pkg::SETS;
        if (kind == oalru_pkg::KIND_QUERY) victims_due.push_back(choose_victim(s, cpu));
        else apply_access(s, int'(way), cpu, is_writeback, hit);
      end
    end
    due_count <= victims_due.size();
  end

endmodule

>>> bench/owner_aware_lru_victim_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owner_aware_lru_victim_select_tb
// Directed and random cache accesses against the victim select block, with
// random stalls on both channels, one long output hold-off and one mid-run drain.
// ----------------------------------------------------------------------------
module owner_aware_lru_victim_select_tb;

  localparam int RANDOM_ITEMS = 1525;
  localparam int DRAIN_AT     = 700;
  localparam int TAIL_AT      = 1400;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 10000;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        in_valid     = 1'b0;
  logic                        in_ready;
  logic                        kind         = oalru_pkg::KIND_QUERY;
  logic [oalru_pkg::CPU_W-1:0] cpu          = '0;
  logic [10:0]                 set_index    = '0;
  logic [oalru_pkg::WAY_W-1:0] way          = '0;
  logic                        is_writeback = 1'b0;
  logic                        hit          = 1'b0;
  logic                        out_valid;
  logic                        out_ready    = 1'b0;
  logic [oalru_pkg::WAY_W-1:0] victim_way;
  logic [1:0]                  victim_reason;

  int   fail_count;
  int   due_count;
  int   accepted    = 0;
  int   idle_cycles = 0;
  logic tail_phase  = 1'b0;

  logic [10:0] hot_sets [6];

  always #5 clk = ~clk;

  owner_aware_lru_victim_select DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .cpu          (cpu),
    .set_index    (set_index),
    .way          (way),
    .is_writeback (is_writeback),
    .hit          (hit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .victim_way   (victim_way),
    .victim_reason(victim_reason)
  );

  owner_aware_lru_victim_select_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .cpu          (cpu),
    .set_index    (set_index),
    .way          (way),
    .is_writeback (is_writeback),
    .hit          (hit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .victim_way   (victim_way),
    .victim_reason(victim_reason),
    .fail_count   (fail_count),
    .due_count    (due_count)
  );

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) accepted <= accepted + 1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_access(input logic k, input logic [oalru_pkg::CPU_W-1:0] c,
                             input logic [10:0] s, input logic [oalru_pkg::WAY_W-1:0] w,
                             input logic wb, input logic h);
    in_valid     <= 1'b1;
    kind         <= k;
    cpu          <= c;
    set_index    <= s;
    way          <= w;
    is_writeback <= wb;
    hit          <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!tail_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // output side: random stalls, one long hold-off, always ready in the tail
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      if (!hold_done && accepted >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    logic                        k;
    logic [oalru_pkg::CPU_W-1:0] c;
    logic [10:0]                 s;
    logic [oalru_pkg::WAY_W-1:0] w;
    logic                        h;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset state, all-ones fields, fills, owner scan and fallback
    send_access(oalru_pkg::KIND_QUERY, 2'd0, 11'h7FF, 4'd0, 1'b0, 1'b0);
    maybe_gap();
    send_access(oalru_pkg::KIND_UPDATE, 2'd3, 11'd0, 4'd15, 1'b1, 1'b0);
    maybe_gap();
    send_access(oalru_pkg::KIND_QUERY, 2'd3, 11'd0, 4'd15, 1'b1, 1'b1);
    for (int i = 0; i < oalru_pkg::WAYS; i++) begin
      maybe_gap();
      c = (i == 3) ? 2'd3 : ((i < 3) ? 2'd0 : 2'd2);
      send_access(oalru_pkg::KIND_UPDATE, c, 11'd1, oalru_pkg::WAY_W'(i), 1'b0, 1'b0);
    end
    send_access(oalru_pkg::KIND_QUERY, 2'd3, 11'd1, 4'd0, 1'b0, 1'b0);
    send_access(oalru_pkg::KIND_QUERY, 2'd1, 11'd1, 4'd0, 1'b0, 1'b0);
    send_access(oalru_pkg::KIND_QUERY, 2'd0, 11'd1, 4'd0, 1'b0, 1'b0);
    send_access(oalru_pkg::KIND_UPDATE, 2'd2, 11'd1, 4'd0, 1'b1, 1'b1);
    send_access(oalru_pkg::KIND_QUERY, 2'd0, 11'd1, 4'd0, 1'b0, 1'b0);
    send_access(oalru_pkg::KIND_UPDATE, 2'd2, 11'd1, 4'd0, 1'b0, 1'b1);
    send_access(oalru_pkg::KIND_QUERY, 2'd0, 11'd1, 4'd0, 1'b0, 1'b0);

    // random: mostly a few hot sets so they fill up, the rest spread wide
    foreach (hot_sets[j]) hot_sets[j] = 11'($urandom_range(0, 2047));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == TAIL_AT) tail_phase = 1'b1;
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0) @(posedge clk);
      end else begin
        maybe_gap();
      end
      s = ($urandom_range(0, 99) < 80) ? hot_sets[$urandom_range(0, 5)]
                                         : 11'($urandom_range(0, 2047));
      k = ($urandom_range(0, 99) < 40) ? oalru_pkg::KIND_QUERY : oalru_pkg::KIND_UPDATE;
      c = oalru_pkg::CPU_W'($urandom_range(0, 3));
      w = oalru_pkg::WAY_W'($urandom_range(0, 15));
      h = ($urandom_range(0, 99) < 55);
      send_access(k, c, s, w, 1'($urandom_range(0, 1)), h);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
